@@ rtl/psa_pkg.sv @@
package psa_pkg;

  // Defaults for the top-level parameters, then fixed page, class and slot sizes
  localparam int NUM_PAGES_DEF    = 256;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int PAGE_BYTES       = 4096;
  localparam int NUM_CLASSES      = 8;
  localparam int OBJ_SLOTS        = 512;

  // Field widths
  localparam int ACTION_W = 3;
  localparam int SIZE_W   = 12;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int BASE_W   = 40;
  localparam int COUNT_W  = 9;
  localparam int HEAD_W   = 10;

  localparam logic [HEAD_W-1:0] NULL_OBJ = 10'd1023;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_INIT        = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PAGE_ALLOC  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PAGE_FREE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SMALL_ALLOC = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SMALL_FREE  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE_FRAME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_MAP_OFFSET = 2'd2;

endpackage

@@ rtl/psa_if.sv @@
interface psa_req_if;
  import psa_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SIZE_W-1:0]   request_size;
  logic [ADDR_W-1:0]   target_address;
  modport source(output valid, action, request_size, target_address, input ready);
  modport sink(input valid, action, request_size, target_address, output ready);
endinterface

interface psa_rsp_if;
  import psa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_address;
  modport source(output valid, status, result_address, input ready);
  modport sink(input valid, status, result_address, output ready);
endinterface

@@ rtl/page_and_slab_allocator_unit.sv @@
// Page and slab allocator over one region of 4 KiB pages. One request word in gives one
// status word out. Per-page state (stack link, size class, slab chain link, free-object
// head, on-stack and slab bits) lives in one synchronous page memory; the free-object
// links live in an object memory of NUM_PAGES x 512 entries. Both have registered reads
// and are walked by a sequencer, so requests are handled one at a time: a small alloc
// walks the class chain slab by slab and, when a new slab is appended, chains every
// object of the class (up to 509 for 8-byte objects at the default header size).
// Init sweeps every page entry, then chains the objects of the eight initial slabs.
// A new request is taken while the previous result still waits on the output.
module page_and_slab_allocator_unit #(
  parameter int NUM_PAGES    = psa_pkg::NUM_PAGES_DEF,
  parameter int HEADER_BYTES = psa_pkg::HEADER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  psa_req_if.sink                         req,
  psa_rsp_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [psa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psa_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES + 1);
  localparam int PIW = $clog2(NUM_PAGES);
  localparam int OIW = PIW + 9;
  localparam int SlabPayload = PAGE_BYTES - HEADER_BYTES;
  localparam logic [PW-1:0] NULL_PAGE = PW'(NUM_PAGES);
  localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

  typedef struct packed {
    logic [PW-1:0]     link;
    logic [2:0]        cls;
    logic [PW-1:0]     nxt;
    logic [HEAD_W-1:0] head;
    logic              on_stack;
    logic              is_slab;
  } pent_t;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INIT_PG = 5'd1;
  localparam logic [4:0] S_BUILD   = 5'd2;
  localparam logic [4:0] S_INIT_FIN= 5'd3;
  localparam logic [4:0] S_PA_RD   = 5'd4;
  localparam logic [4:0] S_PA_WR   = 5'd5;
  localparam logic [4:0] S_PF_CHK  = 5'd6;
  localparam logic [4:0] S_PF_RD   = 5'd7;
  localparam logic [4:0] S_SA_RD   = 5'd8;
  localparam logic [4:0] S_SA_CHK  = 5'd9;
  localparam logic [4:0] S_SA_OBJ  = 5'd10;
  localparam logic [4:0] S_POP_RD  = 5'd11;
  localparam logic [4:0] S_POP_WR  = 5'd12;
  localparam logic [4:0] S_TAIL_RD = 5'd13;
  localparam logic [4:0] S_TAIL_WR = 5'd14;
  localparam logic [4:0] S_SF_IDX  = 5'd15;
  localparam logic [4:0] S_SF_RD   = 5'd16;
  localparam logic [4:0] S_ADDR    = 5'd17;
  localparam logic [4:0] S_ADDR2   = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  function automatic logic [9:0] obj_count(input logic [2:0] c);
    return 10'(SlabPayload >> (4'd3 + 4'(c)));
  endfunction

  // Configuration registers
  logic [BASE_W-1:0]  pool_base_frame;
  logic [COUNT_W-1:0] pool_page_count;
  logic [ADDR_W-1:0]  direct_map_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_frame   <= '0;
      pool_page_count   <= 9'd256;
      direct_map_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_BASE_FRAME:   pool_base_frame   <= cfg_data[BASE_W-1:0];
        REG_POOL_PAGE_COUNT:   pool_page_count   <= cfg_data[COUNT_W-1:0];
        REG_DIRECT_MAP_OFFSET: direct_map_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Usable pages, saturated at the memory depth
  logic [PW-1:0] usable;
  always_comb begin
    if (32'(pool_page_count) > NUM_PAGES) usable = NULL_PAGE;
    else usable = PW'(pool_page_count);
  end

  // Control and payload registers
  logic [4:0]          state;
  logic                ready_flag;
  logic [PW-1:0]       top;
  logic [ACTION_W-1:0] act;
  logic [ADDR_W-1:0]   tgt;
  logic [ADDR_W-1:0]   phys;
  logic [ADDR_W-1:0]   pa;
  logic [PW-1:0]       init_i;
  logic [PW-1:0]       pg;
  logic [PW-1:0]       s;
  logic [PW-1:0]       tail;
  logic [PW-1:0]       steps;
  logic [2:0]          cls;
  logic [8:0]          k;
  logic [8:0]          bk;
  pent_t               ent;
  logic [PW-1:0]       class_first [NUM_CLASSES];
  logic [STATUS_W-1:0] st;
  logic [ADDR_W-1:0]   res;
  logic                out_valid;
  logic [STATUS_W-1:0] out_st;
  logic [ADDR_W-1:0]   out_addr;
  logic                emit;

  // Memories
  pent_t             page_mem [NUM_PAGES];
  logic [HEAD_W-1:0] obj_mem [NUM_PAGES * OBJ_SLOTS];
  pent_t             prd;
  pent_t             pwd;
  logic              pwe;
  logic [PIW-1:0]    pwa;
  logic [PIW-1:0]    pra;
  logic [HEAD_W-1:0] ord;
  logic [HEAD_W-1:0] owd;
  logic              owe;
  logic [OIW-1:0]    owa;
  logic [OIW-1:0]    ora;

  always_ff @(posedge clk) begin
    if (pwe) page_mem[pwa] <= pwd;
    prd <= page_mem[pra];
  end

  always_ff @(posedge clk) begin
    if (owe) obj_mem[owa] <= owd;
    ord <= obj_mem[ora];
  end

  // Size class of the incoming request
  logic [2:0] req_cls;
  always_comb begin
    req_cls = 3'd7;
    for (int j = 6; j >= 0; j--) begin
      if (req.request_size <= 12'(8 << j)) req_cls = 3'(j);
    end
  end

  // Page index from a physical address
  logic [ADDR_W-1:0] pf_idx64;
  logic [ADDR_W-1:0] sf_idx64;
  logic              pf_in_pool;
  logic              sf_in_pool;
  assign pf_idx64 = {12'b0, tgt[63:12]} - {24'b0, pool_base_frame};
  assign sf_idx64 = {12'b0, phys[63:12]} - {24'b0, pool_base_frame};
  assign pf_in_pool = pf_idx64 < 64'(usable);
  assign sf_in_pool = sf_idx64 < 64'(usable);

  // Object checks for small free
  logic [11:0] sf_off;
  logic [11:0] sf_off2;
  logic [11:0] sf_mask;
  logic [11:0] sf_k;
  logic        sf_ok;
  always_comb begin
    sf_off  = phys[11:0];
    sf_off2 = sf_off - 12'(HEADER_BYTES);
    sf_mask = (12'd8 << prd.cls) - 12'd1;
    sf_k    = sf_off2 >> (4'd3 + 4'(prd.cls));
    sf_ok   = prd.is_slab && (sf_off >= 12'(HEADER_BYTES)) && ((sf_off2 & sf_mask) == 12'd0)
              && (10'(sf_k) < obj_count(prd.cls));
  end

  logic       pf_ok;
  assign pf_ok = !prd.on_stack && !prd.is_slab;

  logic [9:0] bcount;
  assign bcount = obj_count(cls);

  // Memory port control
  always_comb begin
    pra = '0;
    pwe = 1'b0;
    pwa = '0;
    pwd = prd;
    ora = {s[PIW-1:0], prd.head[8:0]};
    owe = 1'b0;
    owa = {pg[PIW-1:0], bk};
    owd = (10'(bk) + 10'd1 < bcount) ? 10'(bk) + 10'd1 : NULL_OBJ;
    case (state)
      S_INIT_PG: begin
        pwe          = 1'b1;
        pwa          = init_i[PIW-1:0];
        pwd.link     = (32'(init_i) + 1 < 32'(usable)) ? init_i + 1'b1 : NULL_PAGE;
        pwd.cls      = init_i[2:0];
        pwd.nxt      = NULL_PAGE;
        pwd.head     = '0;
        pwd.on_stack = (init_i >= PW'(8)) && (init_i < usable);
        pwd.is_slab  = init_i < PW'(8);
      end
      S_BUILD: owe = 1'b1;
      S_PA_RD, S_POP_RD: pra = top[PIW-1:0];
      S_PA_WR: begin
        pwe          = 1'b1;
        pwa          = top[PIW-1:0];
        pwd.on_stack = 1'b0;
      end
      S_PF_CHK: pra = pf_idx64[PIW-1:0];
      S_PF_RD: begin
        pwe          = pf_ok;
        pwa          = pg[PIW-1:0];
        pwd.link     = top;
        pwd.on_stack = 1'b1;
      end
      S_SA_RD: pra = s[PIW-1:0];
      S_SA_OBJ: begin
        pwe      = 1'b1;
        pwa      = s[PIW-1:0];
        pwd      = ent;
        pwd.head = ord;
      end
      S_POP_WR: begin
        pwe          = 1'b1;
        pwa          = top[PIW-1:0];
        pwd.cls      = cls;
        pwd.nxt      = NULL_PAGE;
        pwd.head     = (bcount > 10'd1) ? 10'd1 : NULL_OBJ;
        pwd.on_stack = 1'b0;
        pwd.is_slab  = 1'b1;
      end
      S_TAIL_RD: pra = tail[PIW-1:0];
      S_TAIL_WR: begin
        pwe     = 1'b1;
        pwa     = tail[PIW-1:0];
        pwd.nxt = pg;
      end
      S_SF_IDX: pra = sf_idx64[PIW-1:0];
      S_SF_RD: begin
        pwe      = sf_ok;
        pwa      = pg[PIW-1:0];
        pwd.head = 10'(sf_k);
        owe      = sf_ok;
        owa      = {pg[PIW-1:0], sf_k[8:0]};
        owd      = prd.head;
      end
      default: ;
    endcase
  end

  // Load the output register when a result is ready and the slot is free
  assign emit = (state == S_DONE) && (!out_valid || rsp.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ready_flag <= 1'b0;
      top        <= NULL_PAGE;
      out_valid  <= 1'b0;
    end else begin
      // hold a new word, or drop a taken one
      if (emit) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act <= req.action;
            tgt <= req.target_address;
            res <= '0;
            cls <= req_cls;
            if (req.action == ACT_INIT) begin
              ready_flag <= 1'b0;
              init_i     <= '0;
              if (usable < PW'(8)) begin
                st    <= ST_OOM;
                state <= S_DONE;
              end else begin
                state <= S_INIT_PG;
              end
            end else if (req.action > ACT_SMALL_FREE) begin
              st    <= ST_IGNORED;
              state <= S_DONE;
            end else if (!ready_flag) begin
              st    <= ST_NOT_READY;
              state <= S_DONE;
            end else begin
              case (req.action)
                ACT_PAGE_ALLOC: state <= S_PA_RD;
                ACT_PAGE_FREE: begin
                  if (req.target_address[11:0] != 12'd0) begin
                    st    <= ST_IGNORED;
                    state <= S_DONE;
                  end else begin
                    state <= S_PF_CHK;
                  end
                end
                ACT_SMALL_ALLOC: begin
                  if (req.request_size >= 12'd1024) begin
                    st    <= ST_TOO_LARGE;
                    state <= S_DONE;
                  end else begin
                    s     <= class_first[req_cls];
                    tail  <= class_first[req_cls];
                    steps <= '0;
                    state <= S_SA_RD;
                  end
                end
                default: begin
                  if (req.target_address == '0) begin
                    st    <= ST_IGNORED;
                    state <= S_DONE;
                  end else begin
                    phys  <= req.target_address - direct_map_offset;
                    state <= S_SF_IDX;
                  end
                end
              endcase
            end
          end
        end

        // write every page entry; first eight pages become slabs
        S_INIT_PG: begin
          if (init_i < PW'(8)) class_first[init_i[2:0]] <= init_i;
          init_i <= init_i + 1'b1;
          if (init_i == LAST_PAGE) begin
            pg    <= '0;
            cls   <= '0;
            bk    <= '0;
            state <= S_BUILD;
          end
        end

        // chain the objects of one slab in ascending order
        S_BUILD: begin
          bk <= bk + 1'b1;
          if (10'(bk) + 10'd1 >= bcount) begin
            bk <= '0;
            if (act == ACT_INIT) begin
              if (cls == 3'd7) begin
                state <= S_INIT_FIN;
              end else begin
                cls <= cls + 3'd1;
                pg  <= pg + 1'b1;
              end
            end else begin
              state <= S_TAIL_RD;
            end
          end
        end

        S_INIT_FIN: begin
          top        <= (usable > PW'(8)) ? PW'(8) : NULL_PAGE;
          ready_flag <= 1'b1;
          st         <= ST_OK;
          state      <= S_DONE;
        end

        // page alloc: pop the stack
        S_PA_RD: begin
          if (top >= NULL_PAGE) begin
            st    <= ST_OOM;
            state <= S_DONE;
          end else begin
            state <= S_PA_WR;
          end
        end

        S_PA_WR: begin
          top   <= prd.link;
          res   <= ({24'b0, pool_base_frame} + 64'(top)) << 12;
          st    <= ST_OK;
          state <= S_DONE;
        end

        // page free: range check, then push
        S_PF_CHK: begin
          pg <= pf_idx64[PW-1:0];
          if (!pf_in_pool) begin
            st    <= ST_IGNORED;
            state <= S_DONE;
          end else begin
            state <= S_PF_RD;
          end
        end

        S_PF_RD: begin
          if (pf_ok) begin
            top <= pg;
            st  <= ST_OK;
          end else begin
            st  <= ST_IGNORED;
          end
          state <= S_DONE;
        end

        // small alloc: walk the class chain
        S_SA_RD: begin
          if (s >= NULL_PAGE || steps == NULL_PAGE) state <= S_POP_RD;
          else state <= S_SA_CHK;
        end

        S_SA_CHK: begin
          if (prd.head != NULL_OBJ) begin
            ent   <= prd;
            k     <= prd.head[8:0];
            cls   <= prd.cls;
            state <= S_SA_OBJ;
          end else begin
            tail  <= s;
            s     <= prd.nxt;
            steps <= steps + 1'b1;
            state <= S_SA_RD;
          end
        end

        S_SA_OBJ: begin
          pg    <= s;
          state <= S_ADDR;
        end

        S_POP_RD: begin
          if (top >= NULL_PAGE) begin
            st    <= ST_OOM;
            state <= S_DONE;
          end else begin
            state <= S_POP_WR;
          end
        end

        S_POP_WR: begin
          pg    <= top;
          top   <= prd.link;
          bk    <= '0;
          state <= S_BUILD;
        end

        // link the new slab behind the chain tail
        S_TAIL_RD: begin
          k <= '0;
          if (tail < NULL_PAGE) state <= S_TAIL_WR;
          else state <= S_ADDR;
        end

        S_TAIL_WR: state <= S_ADDR;

        // small free: locate the page, then push the object
        S_SF_IDX: begin
          pg <= sf_idx64[PW-1:0];
          if (!sf_in_pool) begin
            st    <= ST_IGNORED;
            state <= S_DONE;
          end else begin
            state <= S_SF_RD;
          end
        end

        S_SF_RD: begin
          st    <= sf_ok ? ST_OK : ST_IGNORED;
          state <= S_DONE;
        end

        // form the object address in two adds
        S_ADDR: begin
          pa    <= (({24'b0, pool_base_frame} + 64'(pg)) << 12)
                   | 64'(12'(HEADER_BYTES) + (12'(k) << (4'd3 + 4'(cls))));
          state <= S_ADDR2;
        end

        S_ADDR2: begin
          res   <= pa + direct_map_offset;
          st    <= ST_OK;
          state <= S_DONE;
        end

        // hand the result word to the output register
        S_DONE: begin
          if (emit) begin
            out_st    <= st;
            out_addr  <= (st == ST_OK) ? res : '0;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_st;
  assign rsp.result_address = out_addr;

endmodule
